[rtl/sbot_pkg.sv]
// shared types, constants and helpers of the swept box overlap test
package sbot_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int OPEN_X_UNITS      = 100;
   localparam int OPEN_Y_UNITS      = 110;
   localparam int AXES              = 2;
   localparam int LANES             = 4;
   localparam int REQ_BITS          = 320;
   localparam int RSP_BITS          = 40;

   typedef struct packed {
      logic [30:0]        proj;
      logic signed [31:0] vel;
      logic signed [31:0] center;
      logic signed [31:0] bcenter;
      logic [30:0]        extent;
   } axis_in_type;

   typedef struct packed {
      logic [31:0] r;
      logic [31:0] d;
      logic        neg;
   } lane_type;

   typedef struct packed {
      logic [AXES-1:0] vzero;
      logic [AXES-1:0] inrng;
   } side_type;

   typedef struct packed {
      logic               collide;
      logic               is_x;
      logic signed [31:0] contact;
   } result_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] res;
      if (v[32] != v[31]) begin
         res = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] res;
      res = v[31] ? 32'(-v) : 32'(v);
      return res;
   endfunction

endpackage

[rtl/swept_box_overlap_test_core.sv]
// Swept box overlap test: one box pair per transfer on req_, one verdict per pair on rsp_.
// req_tdata carries both axes of one pair, velocity relative to box B; rsp_tdata returns
// collide, is_x and the contact time (zero unless collide). csr_ writes frame_end_time
// (Q16.16, unsigned) and is accepted in every cycle; write it only while no pair is open.
// A new pair is taken every cycle while req_tready is high (FRAC_BITS is 16 at Q16.16).
// A pair passes four setup stages, one divider cell per quotient bit (32 + FRAC_BITS
// cells, each advancing all four sweep times one bit), three decision stages and the
// output register on its way to rsp_tvalid. The divider cell chain is the longest part
// of the pipeline; throughput is one pair per cycle while rsp_tready does not stall it.
// When rsp_tready is low the result waits in the output register and the pipeline
// keeps moving until its last stage holds a result, then req_tready drops until the
// waiting result is taken. Bubbles further up are not squeezed out.
// Reset (synchronous, active high) empties the pipeline, drops rsp_tvalid and sets
// frame_end_time to 1.0.
module swept_box_overlap_test_core #(
   parameter int FRAC_BITS = sbot_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // src_proj_x, src_proj_y, rel_vel_x, rel_vel_y, src_center_x, src_center_y,
   // dest_center_x, dest_center_y, dest_extent_x, dest_extent_y, zero pad
   input  logic [sbot_pkg::REQ_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // collide, is_x, contact_time, zero pad
   output logic [sbot_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic                          csr_tvalid,
   output logic                          csr_tready,
   // frame_end_time, zero pad
   input  logic [31:0]                   csr_tdata
);
   import sbot_pkg::*;

   localparam int DW = 32 + FRAC_BITS;
   localparam logic [30:0] FRAME_END_RESET = 31'(1 << FRAC_BITS);

   logic [30:0]          frame_end_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   logic                 adv;
   axis_in_type [AXES-1:0] in_axis;

   logic                     c_valid [DW+1];
   side_type                 c_side  [DW+1];
   lane_type [LANES-1:0]     c_lane  [DW+1];
   logic [LANES-1:0][DW-1:0] c_n     [DW+1];

   logic       last_valid;
   result_type last_result;
   logic       load;

   assign in_axis[0].proj    = req_tdata[30:0];
   assign in_axis[1].proj    = req_tdata[61:31];
   assign in_axis[0].vel     = req_tdata[93:62];
   assign in_axis[1].vel     = req_tdata[125:94];
   assign in_axis[0].center  = req_tdata[157:126];
   assign in_axis[1].center  = req_tdata[189:158];
   assign in_axis[0].bcenter = req_tdata[221:190];
   assign in_axis[1].bcenter = req_tdata[253:222];
   assign in_axis[0].extent  = req_tdata[284:254];
   assign in_axis[1].extent  = req_tdata[315:285];

   assign adv        = !last_valid || !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign load       = last_valid && (!rsp_valid_ff || rsp_tready);

   sbot_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_axis   (in_axis),
      .out_valid (c_valid[0]),
      .out_side  (c_side[0]),
      .out_lane  (c_lane[0]),
      .out_n     (c_n[0])
   );

   for (genvar j = 0; j < DW; j++) begin : g_cell
      sbot_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c_valid[j]),
         .in_side   (c_side[j]),
         .in_lane   (c_lane[j]),
         .in_n      (c_n[j]),
         .out_valid (c_valid[j+1]),
         .out_side  (c_side[j+1]),
         .out_lane  (c_lane[j+1]),
         .out_n     (c_n[j+1])
      );
   end

   sbot_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .frame_end  (frame_end_ff),
      .in_valid   (c_valid[DW]),
      .in_side    (c_side[DW]),
      .in_lane    (c_lane[DW]),
      .in_n       (c_n[DW]),
      .out_valid  (last_valid),
      .out_result (last_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         frame_end_ff <= FRAME_END_RESET;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_tvalid) begin
            frame_end_ff <= csr_tdata[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= last_result;
      end
   end

   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.contact, rsp_ff.is_x, rsp_ff.collide};

   a_empty_output_never_stalls: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty output register");

   a_no_collide_zero_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.collide |-> rsp_ff.contact == 32'sd0)
      else $error("contact time set without a collision");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");

endmodule

[rtl/sbot_front.sv]
// slab bounds, sweep distances and divider operand setup
module sbot_front #(
   parameter int FRAC_BITS = sbot_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic                                          in_valid,
   input  sbot_pkg::axis_in_type [sbot_pkg::AXES-1:0]    in_axis,
   output logic                                          out_valid,
   output sbot_pkg::side_type                            out_side,
   output sbot_pkg::lane_type [sbot_pkg::LANES-1:0]      out_lane,
   output logic [sbot_pkg::LANES-1:0][31+FRAC_BITS:0]    out_n
);
   import sbot_pkg::*;

   localparam int DW = 32 + FRAC_BITS;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [AXES-1:0][30:0]        w_ff, w_in;
   logic signed [31:0]           vel1_ff [AXES], c1_ff [AXES], bc1_ff [AXES];
   logic signed [31:0]           lo_ff [AXES], hi_ff [AXES], lo_in [AXES], hi_in [AXES];
   logic signed [31:0]           vel2_ff [AXES], c2_ff [AXES];
   logic signed [31:0]           dlo_ff [AXES], dhi_ff [AXES], dlo_in [AXES], dhi_in [AXES];
   logic signed [31:0]           vel3_ff [AXES];
   side_type                     side3_ff, side3_in, side4_ff;
   lane_type [LANES-1:0]         lane_ff, lane_in;
   logic [LANES-1:0][DW-1:0]     n_ff, n_in;

   always_comb begin
      logic [31:0] sum;
      for (int a = 0; a < AXES; a++) begin
         sum = {1'b0, in_axis[a].extent} + {1'b0, in_axis[a].proj};
         w_in[a] = sum[31] ? 31'h7fff_ffff : sum[30:0];
         lo_in[a] = sat33({bc1_ff[a][31], bc1_ff[a]} - {2'b00, w_ff[a]});
         hi_in[a] = sat33({bc1_ff[a][31], bc1_ff[a]} + {2'b00, w_ff[a]});
         dlo_in[a] = sat33({lo_ff[a][31], lo_ff[a]} - {c2_ff[a][31], c2_ff[a]});
         dhi_in[a] = sat33({hi_ff[a][31], hi_ff[a]} - {c2_ff[a][31], c2_ff[a]});
         side3_in.vzero[a] = (vel2_ff[a] == 32'sd0);
         side3_in.inrng[a] = !((c2_ff[a] < lo_ff[a]) || (c2_ff[a] > hi_ff[a]));
         lane_in[2*a].r     = '0;
         lane_in[2*a].d     = mag32(vel3_ff[a]);
         lane_in[2*a].neg   = dlo_ff[a][31] ^ vel3_ff[a][31];
         lane_in[2*a+1].r   = '0;
         lane_in[2*a+1].d   = mag32(vel3_ff[a]);
         lane_in[2*a+1].neg = dhi_ff[a][31] ^ vel3_ff[a][31];
         n_in[2*a]   = {mag32(dlo_ff[a]), {FRAC_BITS{1'b0}}};
         n_in[2*a+1] = {mag32(dhi_ff[a]), {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff     <= w_in;
         side3_ff <= side3_in;
         side4_ff <= side3_ff;
         lane_ff  <= lane_in;
         n_ff     <= n_in;
         for (int a = 0; a < AXES; a++) begin
            vel1_ff[a] <= in_axis[a].vel;
            c1_ff[a]   <= in_axis[a].center;
            bc1_ff[a]  <= in_axis[a].bcenter;
            lo_ff[a]   <= lo_in[a];
            hi_ff[a]   <= hi_in[a];
            vel2_ff[a] <= vel1_ff[a];
            c2_ff[a]   <= c1_ff[a];
            dlo_ff[a]  <= dlo_in[a];
            dhi_ff[a]  <= dhi_in[a];
            vel3_ff[a] <= vel2_ff[a];
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = side4_ff;
   assign out_lane  = lane_ff;
   assign out_n     = n_ff;

endmodule

[rtl/sbot_div_cell.sv]
// one restoring division step for all four sweep times
module sbot_div_cell #(
   parameter int FRAC_BITS = sbot_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic                                          in_valid,
   input  sbot_pkg::side_type                            in_side,
   input  sbot_pkg::lane_type [sbot_pkg::LANES-1:0]      in_lane,
   input  logic [sbot_pkg::LANES-1:0][31+FRAC_BITS:0]    in_n,
   output logic                                          out_valid,
   output sbot_pkg::side_type                            out_side,
   output sbot_pkg::lane_type [sbot_pkg::LANES-1:0]      out_lane,
   output logic [sbot_pkg::LANES-1:0][31+FRAC_BITS:0]    out_n
);
   import sbot_pkg::*;

   localparam int DW = 32 + FRAC_BITS;

   logic                     valid_ff;
   side_type                 side_ff;
   lane_type [LANES-1:0]     lane_ff, lane_in;
   logic [LANES-1:0][DW-1:0] n_ff, n_in;

   always_comb begin
      logic [32:0] shifted;
      logic [32:0] trial;
      logic        ge;
      for (int k = 0; k < LANES; k++) begin
         shifted = {in_lane[k].r, in_n[k][DW-1]};
         trial   = shifted - {1'b0, in_lane[k].d};
         ge      = !trial[32];
         lane_in[k].d   = in_lane[k].d;
         lane_in[k].neg = in_lane[k].neg;
         lane_in[k].r   = ge ? trial[31:0] : shifted[31:0];
         n_in[k]        = {in_n[k][DW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= in_side;
         lane_ff <= lane_in;
         n_ff    <= n_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_lane  = lane_ff;
   assign out_n     = n_ff;

endmodule

[rtl/sbot_back.sv]
// quotient saturation, axis hit tests and the final overlap decision
module sbot_back #(
   parameter int FRAC_BITS = sbot_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic [30:0]                                   frame_end,
   input  logic                                          in_valid,
   input  sbot_pkg::side_type                            in_side,
   input  sbot_pkg::lane_type [sbot_pkg::LANES-1:0]      in_lane,
   input  logic [sbot_pkg::LANES-1:0][31+FRAC_BITS:0]    in_n,
   output logic                                          out_valid,
   output sbot_pkg::result_type                          out_result
);
   import sbot_pkg::*;

   localparam int DW = 32 + FRAC_BITS;
   localparam logic [DW-1:0] POS_LIMIT = {{(DW-32){1'b0}}, 32'h7fff_ffff};
   localparam logic [DW-1:0] NEG_LIMIT = {{(DW-32){1'b0}}, 32'h8000_0000};
   localparam logic signed [31:0] OPEN_X = 32'(OPEN_X_UNITS << FRAC_BITS);
   localparam logic signed [31:0] OPEN_Y = 32'(OPEN_Y_UNITS << FRAC_BITS);

   logic v1_ff, v2_ff, v3_ff;

   logic signed [31:0] t_ff [LANES];
   logic signed [31:0] t_in [LANES];
   side_type           side1_ff;
   logic signed [31:0] tc_ff [AXES], to_ff [AXES], tc_in [AXES], to_in [AXES];
   logic [AXES-1:0]    hit_ff, hit_in;
   result_type         res_ff, res_in;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (!in_lane[k].neg) begin
            t_in[k] = (in_n[k] > POS_LIMIT) ? 32'sh7fff_ffff : $signed(in_n[k][31:0]);
         end else begin
            t_in[k] = (in_n[k] > NEG_LIMIT) ? 32'sh8000_0000 : $signed(-in_n[k][31:0]);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         if (side1_ff.vzero[a]) begin
            tc_in[a]  = 32'sd0;
            to_in[a]  = (a == 0) ? OPEN_X : OPEN_Y;
            hit_in[a] = side1_ff.inrng[a];
         end else begin
            if (t_ff[2*a+1] < t_ff[2*a]) begin
               tc_in[a] = t_ff[2*a+1];
               to_in[a] = t_ff[2*a];
            end else begin
               tc_in[a] = t_ff[2*a];
               to_in[a] = t_ff[2*a+1];
            end
            hit_in[a] = !(tc_in[a] > $signed({1'b0, frame_end})) && !(to_in[a] < 32'sd0);
         end
      end
   end

   always_comb begin
      logic signed [31:0] latest;
      logic signed [31:0] earliest;
      logic               y_later;
      y_later  = tc_ff[1] > tc_ff[0];
      latest   = y_later ? tc_ff[1] : tc_ff[0];
      earliest = (to_ff[0] < to_ff[1]) ? to_ff[0] : to_ff[1];
      res_in   = '0;
      if (hit_ff[0] && hit_ff[1]) begin
         res_in.is_x = y_later;
         if (latest < earliest) begin
            res_in.collide = 1'b1;
            res_in.contact = latest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= in_side;
         hit_ff   <= hit_in;
         res_ff   <= res_in;
         for (int k = 0; k < LANES; k++) begin
            t_ff[k] <= t_in[k];
         end
         for (int a = 0; a < AXES; a++) begin
            tc_ff[a] <= tc_in[a];
            to_ff[a] <= to_in[a];
         end
      end
   end

   assign out_valid  = v3_ff;
   assign out_result = res_ff;

endmodule

[test/swept_box_overlap_test_core_test.sv]
// testbench of the swept box overlap test core: directed table, random pairs, predictor check
module swept_box_overlap_test_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sbot_pkg::*;

   typedef struct packed {
      logic [30:0]        proj_x;
      logic [30:0]        proj_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] ctr_x;
      logic signed [31:0] ctr_y;
      logic signed [31:0] box_x;
      logic signed [31:0] box_y;
      logic [30:0]        ext_x;
      logic [30:0]        ext_y;
   } pair_type;

   typedef struct packed {
      pair_type   pair;
      logic       known;
      result_type verdict;
   } row_type;

   localparam longint ONE = 64'sd65536;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;
   localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] PMIN = 32'sh8000_0000;
   localparam logic [30:0] UMAX = 31'h7fff_ffff;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic csr_tvalid;
   logic csr_tready;
   logic [31:0] csr_tdata;

   logic [30:0] frame_end;
   result_type verdicts_due[$];
   int errors;
   int cycles;
   int send_idle_pct;
   int recv_stall_pct;

   swept_box_overlap_test_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp32(input longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic bit slab_hit(input longint proj, input longint vel, input longint ctr,
                                   input longint box, input longint ext,
                                   inout longint t_close, inout longint t_open);
      longint widened, lo, hi, d_lo, d_hi, tc, topen, swap;
      widened = clamp32(ext + proj);
      lo = clamp32(box - widened);
      hi = clamp32(box + widened);
      if (vel == 0) return !(ctr < lo || ctr > hi);
      d_lo = clamp32(lo - ctr);
      d_hi = clamp32(hi - ctr);
      tc = clamp32((d_lo * ONE) / vel);
      topen = clamp32((d_hi * ONE) / vel);
      if (topen < tc) begin
         swap = tc;
         tc = topen;
         topen = swap;
      end
      if (tc > longint'(frame_end)) return 1'b0;
      if (topen < 0) return 1'b0;
      t_close = tc;
      t_open = topen;
      return 1'b1;
   endfunction

   function automatic result_type overlap_verdict(input pair_type p);
      longint cx, ox, cy, oy, latest, earliest;
      bit hx, hy;
      result_type r;
      cx = 0;
      ox = 100 * ONE;
      cy = 0;
      oy = 110 * ONE;
      r = '0;
      hx = slab_hit(longint'(p.proj_x), longint'(p.vel_x), longint'(p.ctr_x),
                    longint'(p.box_x), longint'(p.ext_x), cx, ox);
      hy = slab_hit(longint'(p.proj_y), longint'(p.vel_y), longint'(p.ctr_y),
                    longint'(p.box_y), longint'(p.ext_y), cy, oy);
      if (hx && hy) begin
         latest = (cy > cx) ? cy : cx;
         earliest = (ox < oy) ? ox : oy;
         r.is_x = (cy > cx);
         if (latest < earliest) begin
            r.collide = 1'b1;
            r.contact = 32'(latest);
         end
      end
      return r;
   endfunction

   function automatic logic [REQ_BITS-1:0] pack_pair(input pair_type p);
      return {4'b0, p.ext_y, p.ext_x, p.box_y, p.box_x, p.ctr_y, p.ctr_x,
              p.vel_y, p.vel_x, p.proj_y, p.proj_x};
   endfunction

   function automatic logic signed [31:0] near_value(input int span_units);
      return 32'($signed({1'b0, $urandom_range(2 * span_units * 65536)})
                 - span_units * 65536);
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      logic [319:0] raw;
      if ($urandom_range(99) < 12) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
         p = raw[$bits(pair_type)-1:0];
      end else begin
         p.proj_x = 31'($urandom_range(4 * 65536));
         p.proj_y = 31'($urandom_range(4 * 65536));
         p.ext_x = 31'($urandom_range(4 * 65536));
         p.ext_y = 31'($urandom_range(4 * 65536));
         p.ctr_x = near_value(12);
         p.ctr_y = near_value(12);
         p.box_x = near_value(3);
         p.box_y = near_value(3);
         p.vel_x = ($urandom_range(99) < 20) ? 32'sd0 : near_value(24);
         p.vel_y = ($urandom_range(99) < 20) ? 32'sd0 : near_value(24);
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task automatic send_pair(input pair_type p, input bit known, input result_type verdict);
      result_type predicted;
      predicted = overlap_verdict(p);
      if (known && predicted != verdict) report_mismatch("table row", predicted, verdict);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_pair(p);
      do @(posedge clock); while (!req_tready);
      verdicts_due.push_back(known ? verdict : predicted);
   endtask

   task automatic write_frame_end(input logic [30:0] value);
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= {1'b0, value};
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      frame_end = value;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.collide = rsp_tdata[0];
         got.is_x = rsp_tdata[1];
         got.contact = rsp_tdata[33:2];
         if (verdicts_due.size() == 0) begin
            report_mismatch("unexpected transfer", got, 0);
         end else begin
            want = verdicts_due.pop_front();
            if (got.collide != want.collide) report_mismatch("collide", got.collide, want.collide);
            if (got.is_x != want.is_x) report_mismatch("is_x", got.is_x, want.is_x);
            if (got.contact != want.contact) report_mismatch("contact_time", got.contact, want.contact);
         end
      end
   end

   initial begin
      row_type rows[12];
      logic [30:0] frame_settings[4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      errors = 0;
      cycles = 0;
      frame_end = 31'(ONE);
      send_idle_pct = 34;
      recv_stall_pct = 77;
      // zero everything, far miss and the all-maximum extreme get typed verdicts
      rows[0] = '{'0, 1'b1, '{1'b1, 1'b0, 32'sd0}};
      rows[1] = '{'{31'd0, 31'd0, 32'sd0, 32'sd0, PMAX, 32'sd0, PMIN, 32'sd0, 31'd0, 31'd0},
                  1'b1, '0};
      rows[2] = '{'{UMAX, UMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, UMAX, UMAX},
                  1'b1, '{1'b1, 1'b0, -32'sd65536}};
      rows[3] = '{'{UMAX, UMAX, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, UMAX, UMAX}, 1'b0, '0};
      rows[4] = '{'{31'd65536, 31'd65536, 32'sd131072, 32'sd0, -32'sd262144, 32'sd0,
                    32'sd0, 32'sd0, 31'd65536, 31'd65536}, 1'b0, '0};
      rows[5] = '{'{31'd65536, 31'd65536, -32'sd131072, 32'sd65536, 32'sd262144,
                    -32'sd196608, 32'sd0, 32'sd0, 31'd32768, 31'd32768}, 1'b0, '0};
      rows[6] = '{'{31'd0, 31'd0, 32'sd1, -32'sd1, -32'sd65536, 32'sd65536, 32'sd0, 32'sd0,
                    31'd0, 31'd0}, 1'b0, '0};
      rows[7] = '{'{31'd65536, 31'd0, 32'sd0, 32'sd65536, 32'sd0, -32'sd2621440, 32'sd0,
                    32'sd0, 31'd0, 31'd65536}, 1'b0, '0};
      rows[8] = '{'{31'd0, 31'd0, 32'sd655360, 32'sd65536, -32'sd655360, -32'sd65536,
                    32'sd0, 32'sd0, 31'd65536, 31'd65536}, 1'b0, '0};
      rows[9] = '{'{31'd65536, 31'd65536, PMAX, PMIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                    31'd0, 31'd0}, 1'b0, '0};
      rows[10] = '{'{31'd0, 31'd0, 32'sd65536, 32'sd65536, 32'sd131072, 32'sd131072,
                     32'sd0, 32'sd0, 31'd65536, 31'd65536}, 1'b0, '0};
      rows[11] = '{'{31'd1, 31'd1, -32'sd1, 32'sd1, 32'sd0, 32'sd0, PMAX, PMIN, 31'd1, 31'd1},
                   1'b0, '0};
      frame_settings = '{31'd0, UMAX, 31'd131072, 31'($urandom_range(8 * 65536))};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].verdict);
      for (int phase = 0; phase < 4; phase++) begin
         write_frame_end(frame_settings[phase]);
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_stall_pct = 77;
            end
            1: begin
               send_idle_pct = 77;
               recv_stall_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < 400; n++) send_pair(random_pair(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/sbot_pkg.sv
rtl/sbot_front.sv
rtl/sbot_div_cell.sv
rtl/sbot_back.sv
rtl/swept_box_overlap_test_core.sv
test/swept_box_overlap_test_core_test.sv
